// ----- design/time_code_frame_decoder_macros.svh -----
// Assertion macros for the time-code frame decoder.
// Sampled on clk; the reset-qualified form depends on an rst_n in scope.
`ifndef TIME_CODE_FRAME_DECODER_MACROS_SVH
`define TIME_CODE_FRAME_DECODER_MACROS_SVH

`ifndef ASSERT_OFF
// Checked only out of reset
`define TCFD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tcfd assertion failed");
// Checked at every edge, reset included
`define TCFD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tcfd assertion failed");
`else
`define TCFD_ASSERT(lbl, prop)
`define TCFD_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- design/tcfd_pkg.sv -----
// Shared types, symbol codes and the slot scan table of the time-code decoder.
// No dependencies.
package tcfd_pkg;

  // Received symbol codes
  localparam logic [1:0] SYM_UNKNOWN = 2'd0;
  localparam logic [1:0] SYM_LOW     = 2'd1;
  localparam logic [1:0] SYM_HIGH    = 2'd2;
  localparam logic [1:0] SYM_MARK    = 2'd3;

  // Field ids; 0..9 match the valid_mask bit order, F_MARK counts markers
  typedef enum logic [3:0] {
    F_MIN    = 4'd0,
    F_HOUR   = 4'd1,
    F_DAY    = 4'd2,
    F_HPAR   = 4'd3,
    F_MPAR   = 4'd4,
    F_SUMMER = 4'd5,
    F_YEAR   = 4'd6,
    F_WEEK   = 4'd7,
    F_LEAP   = 4'd8,
    F_STOP   = 4'd9,
    F_MARK   = 4'd10
  } field_t;

  localparam int FIELD_NUM = 11;
  localparam int MASK_W    = 10;
  localparam int ACC_W     = 9;
  localparam int TAB_LEN   = 53;
  localparam int IDX_W     = 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_WRITE,
    ST_SCAN,
    ST_FLUSH,
    ST_DONE
  } state_t;

  // One scan step: which field, which slot, which weight
  typedef struct packed {
    field_t      field;
    logic [5:0]  slot;
    logic [7:0]  weight;
  } entry_t;

  // Control into the accumulator unit
  typedef struct packed {
    logic        clr;
    logic        en;
    field_t      field;
    logic [7:0]  weight;
    logic [1:0]  sym;
  } step_t;

  // Result word, declared high to low so the packed value is the tdata layout
  typedef struct packed {
    logic [2:0]  marker_count;
    logic [1:0]  parity_ok;
    logic [9:0]  valid_mask;
    logic [5:0]  stop_notice;
    logic [1:0]  leap_second;
    logic [1:0]  summer_time;
    logic [1:0]  parity_bits;
    logic [2:0]  weekday;
    logic [7:0]  year;
    logic [8:0]  day_of_year;
    logic [5:0]  hours;
    logic [6:0]  minutes;
  } result_t;

  // Scan order: every field slot with its weight, marker positions last
  function automatic entry_t tab_entry(input logic [IDX_W-1:0] idx);
    entry_t e;
    e = '{F_MARK, 6'd0, 8'd1};
    case (idx)
      6'd0:  e = '{F_MIN, 6'd1, 8'd40};
      6'd1:  e = '{F_MIN, 6'd2, 8'd20};
      6'd2:  e = '{F_MIN, 6'd3, 8'd10};
      6'd3:  e = '{F_MIN, 6'd5, 8'd8};
      6'd4:  e = '{F_MIN, 6'd6, 8'd4};
      6'd5:  e = '{F_MIN, 6'd7, 8'd2};
      6'd6:  e = '{F_MIN, 6'd8, 8'd1};
      6'd7:  e = '{F_HOUR, 6'd12, 8'd20};
      6'd8:  e = '{F_HOUR, 6'd13, 8'd10};
      6'd9:  e = '{F_HOUR, 6'd15, 8'd8};
      6'd10: e = '{F_HOUR, 6'd16, 8'd4};
      6'd11: e = '{F_HOUR, 6'd17, 8'd2};
      6'd12: e = '{F_HOUR, 6'd18, 8'd1};
      6'd13: e = '{F_DAY, 6'd22, 8'd200};
      6'd14: e = '{F_DAY, 6'd23, 8'd100};
      6'd15: e = '{F_DAY, 6'd25, 8'd80};
      6'd16: e = '{F_DAY, 6'd26, 8'd40};
      6'd17: e = '{F_DAY, 6'd27, 8'd20};
      6'd18: e = '{F_DAY, 6'd28, 8'd10};
      6'd19: e = '{F_DAY, 6'd30, 8'd8};
      6'd20: e = '{F_DAY, 6'd31, 8'd4};
      6'd21: e = '{F_DAY, 6'd32, 8'd2};
      6'd22: e = '{F_DAY, 6'd33, 8'd1};
      6'd23: e = '{F_HPAR, 6'd36, 8'd1};
      6'd24: e = '{F_MPAR, 6'd37, 8'd1};
      6'd25: e = '{F_SUMMER, 6'd38, 8'h02};
      6'd26: e = '{F_SUMMER, 6'd39, 8'h01};
      6'd27: e = '{F_YEAR, 6'd41, 8'd80};
      6'd28: e = '{F_YEAR, 6'd42, 8'd40};
      6'd29: e = '{F_YEAR, 6'd43, 8'd20};
      6'd30: e = '{F_YEAR, 6'd44, 8'd10};
      6'd31: e = '{F_YEAR, 6'd45, 8'd8};
      6'd32: e = '{F_YEAR, 6'd46, 8'd4};
      6'd33: e = '{F_YEAR, 6'd47, 8'd2};
      6'd34: e = '{F_YEAR, 6'd48, 8'd1};
      6'd35: e = '{F_WEEK, 6'd50, 8'd4};
      6'd36: e = '{F_WEEK, 6'd51, 8'd2};
      6'd37: e = '{F_WEEK, 6'd52, 8'd1};
      6'd38: e = '{F_LEAP, 6'd53, 8'h02};
      6'd39: e = '{F_LEAP, 6'd54, 8'h01};
      6'd40: e = '{F_STOP, 6'd50, 8'h20};
      6'd41: e = '{F_STOP, 6'd51, 8'h10};
      6'd42: e = '{F_STOP, 6'd52, 8'h08};
      6'd43: e = '{F_STOP, 6'd53, 8'h04};
      6'd44: e = '{F_STOP, 6'd54, 8'h02};
      6'd45: e = '{F_STOP, 6'd55, 8'h01};
      6'd46: e = '{F_MARK, 6'd0, 8'd1};
      6'd47: e = '{F_MARK, 6'd9, 8'd1};
      6'd48: e = '{F_MARK, 6'd19, 8'd1};
      6'd49: e = '{F_MARK, 6'd29, 8'd1};
      6'd50: e = '{F_MARK, 6'd39, 8'd1};
      6'd51: e = '{F_MARK, 6'd49, 8'd1};
      6'd52: e = '{F_MARK, 6'd59, 8'd1};
      default: e = '{F_MARK, 6'd0, 8'd1};
    endcase
    return e;
  endfunction

endpackage

// ----- design/time_code_frame_decoder.sv -----
// Channel | beat content                                  | handshake
// in_     | tuser: op; tdata: second, symbol              | in_tvalid / in_tready
// out_    | tdata: decoded frame fields (see port comment) | out_tvalid / out_tready
//
// A beat passes through the accept, the fold (up to four subtracts of the slot count),
// the write, a 53-step scan over the symbol RAM's single read port into one shared
// adder, a flush and a load.
// in_tready is high only when idle; a load waits while the output register is full and out_tready is low.
// Reset (rst_n, synchronous) clears the per-slot valid bits: every slot reads
// unknown. A clear command clears them the same way.
// Depends on tcfd_pkg, tcfd_ram, tcfd_accum and the assertion macro header.
`include "time_code_frame_decoder_macros.svh"

module time_code_frame_decoder #(
  parameter int SLOT_COUNT = 60
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // op
  input  logic [15:0] in_tdata,   // second[7:0], symbol[9:8], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  // minutes[6:0], hours[12:7], day_of_year[21:13], year[29:22],
  // weekday[32:30], parity_bits[34:33], summer_time[36:35],
  // leap_second[38:37], stop_notice[44:39], valid_mask[54:45],
  // parity_ok[56:55], marker_count[59:57], zero pad
  output logic [63:0] out_tdata
);
  import tcfd_pkg::*;

  localparam int ADDR_W = $clog2(SLOT_COUNT);

  state_t            state_r, state_nxt;
  logic              op_r;
  logic [7:0]        slot_r;
  logic [1:0]        sym_r;
  logic [IDX_W-1:0]  idx_r;
  logic [SLOT_COUNT-1:0] valid_r;
  entry_t            cur_ent;
  entry_t            ent_r;
  logic              ent_vld_r;
  logic              proc_r;
  logic [1:0]        rd_data;
  step_t             step;
  result_t           res;
  result_t           out_res_r;
  logic              out_valid_r;

  logic              ctl_ready;
  logic              ctl_we;
  logic              ctl_vclr;
  logic              ctl_aclr;
  logic              ctl_issue;
  logic              ctl_load;

  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;

  assign cur_ent = tab_entry(idx_r);
  assign waddr   = slot_r[ADDR_W-1:0];
  assign raddr   = ADDR_W'(cur_ent.slot);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_REDUCE;
      ST_REDUCE: if (slot_r < 8'(SLOT_COUNT)) state_nxt = ST_WRITE;
      ST_WRITE:  state_nxt = ST_SCAN;
      ST_SCAN:   if (idx_r == IDX_W'(TAB_LEN - 1)) state_nxt = ST_FLUSH;
      ST_FLUSH:  state_nxt = ST_DONE;
      ST_DONE:   if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    ctl_ready = 1'b0;
    ctl_we    = 1'b0;
    ctl_vclr  = 1'b0;
    ctl_aclr  = 1'b0;
    ctl_issue = 1'b0;
    ctl_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        ctl_ready = 1'b1;
      end
      ST_WRITE: begin
        ctl_we   = !op_r;
        ctl_vclr = op_r;
        ctl_aclr = 1'b1;
      end
      ST_SCAN: begin
        ctl_issue = 1'b1;
      end
      ST_DONE: begin
        ctl_load = !out_valid_r || out_tready;
      end
      default: begin
        ctl_ready = 1'b0;
      end
    endcase
  end

  assign in_tready = ctl_ready;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      proc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      proc_r  <= ctl_issue;
      if (ctl_vclr) begin
        valid_r <= '0;
      end else if (ctl_we) begin
        valid_r[waddr] <= 1'b1;
      end
      if (ctl_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Beat capture, slot folding, scan datapath and output load
  always_ff @(posedge clk) begin
    if (ctl_ready && in_tvalid) begin
      op_r   <= in_tuser;
      slot_r <= in_tdata[7:0];
      sym_r  <= in_tdata[9:8];
    end else if (state_r == ST_REDUCE && slot_r >= 8'(SLOT_COUNT)) begin
      slot_r <= slot_r - 8'(SLOT_COUNT);
    end
    if (ctl_aclr) begin
      idx_r <= '0;
    end else if (ctl_issue) begin
      idx_r <= idx_r + 1'b1;
    end
    if (ctl_issue) begin
      ent_r     <= cur_ent;
      ent_vld_r <= valid_r[raddr];
    end
    if (ctl_load) begin
      out_res_r <= res;
    end
  end

  tcfd_ram #(
    .WIDTH (2),
    .DEPTH (SLOT_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ctl_we),
    .waddr (waddr),
    .wdata (sym_r),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // A slot never written since the last clear reads as unknown
  always_comb begin
    step.clr    = ctl_aclr;
    step.en     = proc_r;
    step.field  = ent_r.field;
    step.weight = ent_r.weight;
    step.sym    = ent_vld_r ? rd_data : SYM_UNKNOWN;
  end

  tcfd_accum u_accum (
    .clk  (clk),
    .step (step),
    .res  (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r};

  // Checks
  `TCFD_ASSERT(a_slot_folded, state_r == ST_WRITE |-> slot_r < 8'(SLOT_COUNT))
  `TCFD_ASSERT(a_clear_empties, (state_r == ST_WRITE && op_r) |=> valid_r == '0)
  `TCFD_ASSERT(a_proc_follows_scan, proc_r |-> $past(state_r) == ST_SCAN)
  `TCFD_ASSERT(a_load_from_done, $rose(out_valid_r) |-> $past(state_r) == ST_DONE)

endmodule

// ----- design/tcfd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcfd_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 60
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/tcfd_accum.sv -----
// Shared weight adder and per-field accumulators of the time-code decoder.
// Depends on tcfd_pkg.
module tcfd_accum (
  input  logic             clk,
  input  tcfd_pkg::step_t  step,
  output tcfd_pkg::result_t res
);
  import tcfd_pkg::*;

  logic [ACC_W-1:0]  acc_r [FIELD_NUM];
  logic [MASK_W-1:0] fvalid_r;
  logic              hcnt_r;
  logic              mcnt_r;

  logic              hit;
  logic              bad;
  logic [ACC_W-1:0]  sum;

  // Shared adder: selected accumulator plus the weight of a hit
  always_comb begin
    if (step.field == F_MARK) begin
      hit = (step.sym == SYM_MARK);
    end else begin
      hit = (step.sym == SYM_HIGH);
    end
    bad = !((step.sym == SYM_HIGH) || (step.sym == SYM_LOW));
    sum = acc_r[step.field] + (hit ? {1'b0, step.weight} : '0);
  end

  // Accumulator update, cleared before each scan
  always_ff @(posedge clk) begin
    if (step.clr) begin
      for (int i = 0; i < FIELD_NUM; i++) begin
        acc_r[i] <= '0;
      end
      fvalid_r <= '1;
      hcnt_r   <= 1'b0;
      mcnt_r   <= 1'b0;
    end else if (step.en) begin
      acc_r[step.field] <= sum;
      if (step.field != F_MARK && bad) begin
        fvalid_r[step.field] <= 1'b0;
      end
      if (step.field == F_HOUR && step.sym == SYM_HIGH) begin
        hcnt_r <= ~hcnt_r;
      end
      if (step.field == F_MIN && step.sym == SYM_HIGH) begin
        mcnt_r <= ~mcnt_r;
      end
    end
  end

  // Result fields from the accumulators
  always_comb begin
    res.minutes      = acc_r[F_MIN][6:0];
    res.hours        = acc_r[F_HOUR][5:0];
    res.day_of_year  = acc_r[F_DAY][8:0];
    res.year         = acc_r[F_YEAR][7:0];
    res.weekday      = acc_r[F_WEEK][2:0];
    res.parity_bits  = {acc_r[F_HPAR][0], acc_r[F_MPAR][0]};
    res.summer_time  = acc_r[F_SUMMER][1:0];
    res.leap_second  = acc_r[F_LEAP][1:0];
    res.stop_notice  = acc_r[F_STOP][5:0];
    res.valid_mask   = fvalid_r;
    res.parity_ok    = {hcnt_r == acc_r[F_HPAR][0], mcnt_r == acc_r[F_MPAR][0]};
    res.marker_count = acc_r[F_MARK][2:0];
  end

endmodule

// ----- dv/time_code_frame_decoder_test.sv -----
// Self-checking testbench for time_code_frame_decoder: directed table, then random frames.
// Predicts untyped results from a local copy of the slot store; checks all per field.
// Depends on tcfd_pkg and the time_code_frame_decoder RTL.
`timescale 1ns / 1ps

module time_code_frame_decoder_test;
  import tcfd_pkg::*;

  localparam int FRAME_SLOTS  = 60;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 200;
  localparam int PHASE_ITEMS  = 234;

  // Beat kinds carried on in_tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tuser   = 1'b0;
  logic [15:0] in_tdata   = '0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [63:0] out_tdata;

  time_code_frame_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Directed stimulus row; typed rows carry their own expected frame
  typedef struct {
    logic        op;
    logic [7:0]  second;
    logic [1:0]  symbol;
    bit          typed;
    result_t     res;
  } beat_row_t;

  logic [1:0] frame_store [FRAME_SLOTS];
  result_t    frame_q [$];
  beat_row_t  dir_rows [$];
  int         mismatch_count = 0;
  int         cycle_count    = 0;
  int         send_idle_pct  = 0;
  int         recv_idle_pct  = 0;
  int         hold_reqs      = 0;
  int         hold_seen      = 0;
  int         hold_left      = 0;

  function automatic bit is_marker_slot(input int s);
    return (s == 0) || (s % 10 == 9);
  endfunction

  // Weight of slot s inside field f, 0 where the field does not read it
  function automatic int field_weight(input int f, input int s);
    int w;
    w = 0;
    case (f)
      F_MIN: begin
        case (s)
          1: w = 40; 2: w = 20; 3: w = 10; 5: w = 8; 6: w = 4; 7: w = 2; 8: w = 1;
          default: w = 0;
        endcase
      end
      F_HOUR: begin
        case (s)
          12: w = 20; 13: w = 10; 15: w = 8; 16: w = 4; 17: w = 2; 18: w = 1;
          default: w = 0;
        endcase
      end
      F_DAY: begin
        case (s)
          22: w = 200; 23: w = 100; 25: w = 80; 26: w = 40; 27: w = 20;
          28: w = 10; 30: w = 8; 31: w = 4; 32: w = 2; 33: w = 1;
          default: w = 0;
        endcase
      end
      F_HPAR:   w = (s == 36) ? 1 : 0;
      F_MPAR:   w = (s == 37) ? 1 : 0;
      F_SUMMER: w = (s == 38) ? 2 : (s == 39) ? 1 : 0;
      F_YEAR: begin
        case (s)
          41: w = 80; 42: w = 40; 43: w = 20; 44: w = 10;
          45: w = 8; 46: w = 4; 47: w = 2; 48: w = 1;
          default: w = 0;
        endcase
      end
      F_WEEK: begin
        case (s)
          50: w = 4; 51: w = 2; 52: w = 1;
          default: w = 0;
        endcase
      end
      F_LEAP: w = (s == 53) ? 2 : (s == 54) ? 1 : 0;
      F_STOP: begin
        case (s)
          50: w = 32; 51: w = 16; 52: w = 8; 53: w = 4; 54: w = 2; 55: w = 1;
          default: w = 0;
        endcase
      end
      default: w = 0;
    endcase
    return w;
  endfunction

  // Decode the current slot store into the frame the block should report
  function automatic result_t decode_frame();
    result_t r;
    int      sum   [MASK_W];
    int      highs [MASK_W];
    bit      clean [MASK_W];
    int      w;
    int      marks;
    for (int f = 0; f < MASK_W; f++) begin
      sum[f]   = 0;
      highs[f] = 0;
      clean[f] = 1'b1;
    end
    for (int f = 0; f < MASK_W; f++) begin
      for (int s = 0; s < FRAME_SLOTS; s++) begin
        w = field_weight(f, s);
        if (w != 0) begin
          if (frame_store[s] == SYM_HIGH) begin
            sum[f]   += w;
            highs[f] += 1;
          end
          if (frame_store[s] != SYM_HIGH && frame_store[s] != SYM_LOW) clean[f] = 1'b0;
        end
      end
    end
    marks = 0;
    for (int s = 0; s < FRAME_SLOTS; s++)
      if (is_marker_slot(s) && frame_store[s] == SYM_MARK) marks++;

    r = '0;
    r.minutes      = sum[F_MIN][6:0];
    r.hours        = sum[F_HOUR][5:0];
    r.day_of_year  = sum[F_DAY][8:0];
    r.year         = sum[F_YEAR][7:0];
    r.weekday      = sum[F_WEEK][2:0];
    r.parity_bits  = {sum[F_HPAR][0], sum[F_MPAR][0]};
    r.summer_time  = sum[F_SUMMER][1:0];
    r.leap_second  = sum[F_LEAP][1:0];
    r.stop_notice  = sum[F_STOP][5:0];
    for (int f = 0; f < MASK_W; f++) r.valid_mask[f] = clean[f];
    r.parity_ok    = {highs[F_HOUR][0] == sum[F_HPAR][0], highs[F_MIN][0] == sum[F_MPAR][0]};
    r.marker_count = marks[2:0];
    return r;
  endfunction

  function automatic void add_row(input logic op, input logic [7:0] sec, input logic [1:0] sym,
                                  input bit typed = 1'b0, input result_t res = '0);
    beat_row_t row;
    row.op     = op;
    row.second = sec;
    row.symbol = sym;
    row.typed  = typed;
    row.res    = res;
    dir_rows.push_back(row);
  endfunction

  // Offer one beat after a random gap; valid stays up for the next beat
  task automatic send_beat(input logic op, input logic [7:0] sec, input logic [1:0] sym,
                           input bit typed = 1'b0, input result_t res = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'd0, sym, sec};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == OP_CLEAR) begin
      for (int s = 0; s < FRAME_SLOTS; s++) frame_store[s] = SYM_UNKNOWN;
    end else begin
      frame_store[sec % FRAME_SLOTS] = sym;
    end
    frame_q.push_back(typed ? res : decode_frame());
  endtask

  task automatic wait_all_frames();
    in_tvalid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
  endtask

  // Symbol that belongs in slot s of a sane frame
  function automatic logic [1:0] frame_symbol(input int s, input int style);
    if (is_marker_slot(s)) return SYM_MARK;
    if (style == 0) return SYM_HIGH;
    if (style == 1) return SYM_LOW;
    return ($urandom_range(1) == 1) ? SYM_HIGH : SYM_LOW;
  endfunction

  // Any second index that lands on slot s
  function automatic logic [7:0] wrap_second(input int s);
    int k;
    k = $urandom_range((255 - s) / FRAME_SLOTS);
    return 8'(s + FRAME_SLOTS * k);
  endfunction

  // Random traffic: full frame sweeps, scattered writes, clears and noise
  task automatic run_random(input int n_items, input bit with_hold);
    int         sent;
    int         pick;
    int         style;
    int         s;
    logic [1:0] sym;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        if (with_hold && sent == 30) hold_reqs <= hold_reqs + 1;
        send_beat(OP_CLEAR, 8'($urandom_range(255)), 2'($urandom_range(3)));
        sent++;
      end else if (pick < 35) begin
        style = $urandom_range(9);
        for (s = 0; s < FRAME_SLOTS; s++) begin
          sym = frame_symbol(s, style);
          if ($urandom_range(99) < 4) sym = 2'($urandom_range(3));
          if (with_hold && sent == 30) hold_reqs <= hold_reqs + 1;
          send_beat(OP_WRITE, wrap_second(s), sym);
          sent++;
        end
      end else begin
        repeat (10) begin
          if (with_hold && sent == 30) hold_reqs <= hold_reqs + 1;
          if ($urandom_range(99) < 70) begin
            s = $urandom_range(FRAME_SLOTS - 1);
            send_beat(OP_WRITE, wrap_second(s), frame_symbol(s, 2));
          end else begin
            send_beat(OP_WRITE, 8'($urandom_range(255)), 2'($urandom_range(3)));
          end
          sent++;
        end
      end
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen  <= hold_reqs;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t %s mismatch: expected %0d, actual %0d", $realtime, name, want, got);
    end
  endtask

  // Compare each output beat with the oldest predicted frame
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      got = result_t'(out_tdata[59:0]);
      if (frame_q.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected beat: expected none, actual %h", $realtime, out_tdata);
      end else begin
        want = frame_q.pop_front();
        check_field("minutes", want.minutes, got.minutes);
        check_field("hours", want.hours, got.hours);
        check_field("day_of_year", want.day_of_year, got.day_of_year);
        check_field("year", want.year, got.year);
        check_field("weekday", want.weekday, got.weekday);
        check_field("parity_bits", want.parity_bits, got.parity_bits);
        check_field("summer_time", want.summer_time, got.summer_time);
        check_field("leap_second", want.leap_second, got.leap_second);
        check_field("stop_notice", want.stop_notice, got.stop_notice);
        check_field("valid_mask", want.valid_mask, got.valid_mask);
        check_field("parity_ok", want.parity_ok, got.parity_ok);
        check_field("marker_count", want.marker_count, got.marker_count);
        check_field("pad", 0, out_tdata[63:60]);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    result_t r_empty;
    result_t r_hour;
    result_t r_mark;

    for (int s = 0; s < FRAME_SLOTS; s++) frame_store[s] = SYM_UNKNOWN;

    // Frames that can be read straight off the slot map
    r_empty           = '0;
    r_empty.parity_ok = 2'b11;
    r_hour            = '0;
    r_hour.hours      = 6'd8;
    r_hour.parity_ok  = 2'b01;
    r_mark            = r_hour;
    r_mark.marker_count = 3'd1;

    // Directed table
    add_row(OP_CLEAR, 8'd0,   SYM_UNKNOWN, 1'b1, r_empty);
    add_row(OP_WRITE, 8'd255, SYM_HIGH,    1'b1, r_hour);
    add_row(OP_WRITE, 8'd0,   SYM_MARK,    1'b1, r_mark);
    add_row(OP_WRITE, 8'd1,   SYM_HIGH);
    add_row(OP_WRITE, 8'd62,  SYM_HIGH);
    add_row(OP_WRITE, 8'd123, SYM_HIGH);
    add_row(OP_WRITE, 8'd245, SYM_HIGH);
    add_row(OP_WRITE, 8'd6,   SYM_HIGH);
    add_row(OP_WRITE, 8'd7,   SYM_HIGH);
    add_row(OP_WRITE, 8'd8,   SYM_HIGH);
    add_row(OP_WRITE, 8'd12,  SYM_HIGH);
    add_row(OP_WRITE, 8'd13,  SYM_HIGH);
    add_row(OP_WRITE, 8'd16,  SYM_HIGH);
    add_row(OP_WRITE, 8'd17,  SYM_HIGH);
    add_row(OP_WRITE, 8'd18,  SYM_HIGH);
    add_row(OP_WRITE, 8'd96,  SYM_HIGH);
    add_row(OP_WRITE, 8'd37,  SYM_LOW);
    add_row(OP_WRITE, 8'd158, SYM_HIGH);
    add_row(OP_WRITE, 8'd39,  SYM_MARK);
    add_row(OP_WRITE, 8'd233, SYM_HIGH);
    add_row(OP_WRITE, 8'd54,  SYM_UNKNOWN);
    add_row(OP_WRITE, 8'd22,  SYM_HIGH);
    add_row(OP_WRITE, 8'd228, SYM_HIGH);
    add_row(OP_WRITE, 8'd50,  SYM_HIGH);
    add_row(OP_WRITE, 8'd37,  SYM_MARK);
    add_row(OP_CLEAR, 8'd255, SYM_MARK);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_beat(dir_rows[i].op, dir_rows[i].second, dir_rows[i].symbol,
                dir_rows[i].typed, dir_rows[i].res);
    wait_all_frames();

    // Sender mostly busy, receiver mostly stalled
    send_idle_pct = 20;
    recv_idle_pct <= 82;
    run_random(PHASE_ITEMS, 1'b0);
    wait_all_frames();

    // Sender mostly idle, receiver mostly ready
    send_idle_pct = 82;
    recv_idle_pct <= 20;
    run_random(PHASE_ITEMS, 1'b0);
    wait_all_frames();

    // Full rate, with one long receiver hold-off
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    run_random(PHASE_ITEMS, 1'b1);
    wait_all_frames();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && frame_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/tcfd_pkg.sv
design/tcfd_ram.sv
design/tcfd_accum.sv
design/time_code_frame_decoder.sv
dv/time_code_frame_decoder_test.sv
